### src/rmq_pkg.sv
// Shared types and constants for the rotation-matrix-to-quaternion block.
// No dependencies; rmq_div_pipe and the top level refer to this package by scoped names.
`timescale 1ns / 1ps

package rmq_pkg;

  localparam int ELEM_W   = 32;  // matrix element and quaternion component width
  localparam int THR_W    = 31;  // trace threshold register width
  localparam int BRANCH_W = 2;
  localparam int SUM_W    = 35;  // radicand sums of four 32-bit terms
  localparam int NUM_W    = 33;  // off-diagonal sums and differences
  localparam int RAD_W    = 33;  // a positive radicand stays below 2^33
  localparam int Q_W      = 32;  // quotient bits produced by the divider
  localparam int N_LANES  = 3;   // off-diagonal components per quaternion

  localparam logic [BRANCH_W-1:0] BR_TRACE = 2'd0;
  localparam logic [BRANCH_W-1:0] BR_COL0  = 2'd1;
  localparam logic [BRANCH_W-1:0] BR_COL1  = 2'd2;
  localparam logic [BRANCH_W-1:0] BR_COL2  = 2'd3;

  localparam logic [ELEM_W-1:0] COMP_MAX = 32'h7FFF_FFFF;
  localparam logic [ELEM_W-1:0] COMP_MIN = 32'h8000_0000;

  typedef struct packed {
    logic signed [ELEM_W-1:0] r00;
    logic signed [ELEM_W-1:0] r01;
    logic signed [ELEM_W-1:0] r02;
    logic signed [ELEM_W-1:0] r10;
    logic signed [ELEM_W-1:0] r11;
    logic signed [ELEM_W-1:0] r12;
    logic signed [ELEM_W-1:0] r20;
    logic signed [ELEM_W-1:0] r21;
    logic signed [ELEM_W-1:0] r22;
  } matrix_t;

  typedef struct packed {
    logic signed [ELEM_W-1:0]   quat_x;
    logic signed [ELEM_W-1:0]   quat_y;
    logic signed [ELEM_W-1:0]   quat_z;
    logic signed [ELEM_W-1:0]   quat_w;
    logic        [BRANCH_W-1:0] branch_used;
    logic                       degenerate;
  } quat_t;

endpackage

### src/rmq_sqrt_pipe.sv
// Pipelined integer square root, one result bit per register stage.
// Depends on nothing but the clock enable and valid bits supplied by the top level.
`timescale 1ns / 1ps

module rmq_sqrt_pipe #(
  parameter int RW    = 32,
  parameter int TAG_W = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [2*RW-1:0]   in_x,
  input  logic [TAG_W-1:0]  in_tag,
  output logic              out_valid,
  output logic [RW-1:0]     out_root,
  output logic [TAG_W-1:0]  out_tag
);

  localparam int REM_W = RW + 2;

  logic              v    [RW];
  logic [REM_W-1:0]  rem  [RW];
  logic [RW-1:0]     root [RW];
  logic [2*RW-1:0]   x    [RW];
  logic [TAG_W-1:0]  tag  [RW];

  for (genvar s = 0; s < RW; s++) begin : g_stage
    localparam int B = RW - 1 - s;
    logic             pv;
    logic [REM_W-1:0] prem;
    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    logic [RW-1:0]    proot;
    logic [2*RW-1:0]  px;
    logic [TAG_W-1:0] ptag;

    if (s == 0) begin : g_first
      assign pv    = in_valid;
      assign prem  = '0;
      assign proot = '0;
      assign px    = in_x;
      assign ptag  = in_tag;
    end else begin : g_next
      assign pv    = v[s-1];
      assign prem  = rem[s-1];
      assign proot = root[s-1];
      assign px    = x[s-1];
      assign ptag  = tag[s-1];
    end

    // Bring down the next two radicand bits and try the trial subtrahend 4r+1.
    assign rem_sh = {prem[REM_W-3:0], px[2*B+1 -: 2]};
    assign trial  = {proot, 2'b01};

    always_ff @(posedge clk) begin
      if (rst) begin
        v[s] <= 1'b0;
      end else if (en) begin
        v[s] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x[s]   <= px;
        tag[s] <= ptag;
        if (rem_sh >= trial) begin
          rem[s]  <= rem_sh - trial;
          root[s] <= {proot[RW-2:0], 1'b1};
        end else begin
          rem[s]  <= rem_sh;
          root[s] <= {proot[RW-2:0], 1'b0};
        end
      end
    end
  end

  assign out_valid = v[RW-1];
  assign out_root  = root[RW-1];
  assign out_tag   = tag[RW-1];

endmodule

### src/rmq_div_pipe.sv
// Three-lane pipelined restoring divider, one quotient bit per register stage.
// Divides each lane's dividend by twice the root; uses rmq_pkg for lane count and widths.
`timescale 1ns / 1ps

module rmq_div_pipe #(
  parameter int RW    = 32,
  parameter int DIV_W = 63,
  parameter int TAG_W = 6
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       en,
  input  logic                                       in_valid,
  input  logic [RW-1:0]                              in_root,
  input  logic [rmq_pkg::N_LANES-1:0][DIV_W-1:0]     in_dividend,
  input  logic [TAG_W-1:0]                           in_tag,
  output logic                                       out_valid,
  output logic [RW-1:0]                              out_root,
  output logic [rmq_pkg::N_LANES-1:0][rmq_pkg::Q_W-1:0] out_quo,
  output logic [rmq_pkg::N_LANES-1:0]                out_ovf,
  output logic [TAG_W-1:0]                           out_tag
);

  localparam int QW    = rmq_pkg::Q_W;
  localparam int NL    = rmq_pkg::N_LANES;
  localparam int REM_W = RW + 2;

  logic              v   [QW];
  logic [RW-1:0]     rt  [QW];
  logic [TAG_W-1:0]  tag [QW];
  logic [REM_W-1:0]  rem [QW][NL];
  logic [QW-1:0]     quo [QW][NL];
  logic [QW-1:0]     lo  [QW][NL];
  logic              ovf [QW][NL];

  for (genvar s = 0; s < QW; s++) begin : g_stage
    localparam int J = QW - 1 - s;
    logic             pv;
    logic [RW-1:0]    proot;
    logic [TAG_W-1:0] ptag;
    logic [REM_W-1:0] dd;

    if (s == 0) begin : g_first
      assign pv    = in_valid;
      assign proot = in_root;
      assign ptag  = in_tag;
    end else begin : g_next
      assign pv    = v[s-1];
      assign proot = rt[s-1];
      assign ptag  = tag[s-1];
    end

    assign dd = REM_W'({proot, 1'b0});

    always_ff @(posedge clk) begin
      if (rst) begin
        v[s] <= 1'b0;
      end else if (en) begin
        v[s] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rt[s]  <= proot;
        tag[s] <= ptag;
      end
    end

    for (genvar l = 0; l < NL; l++) begin : g_lane
      logic [REM_W-1:0] prem;
      logic [REM_W-1:0] rsh;
      logic [QW-1:0]    plo;
      logic [QW-1:0]    pq;
      logic [QW-1:0]    qn;
      logic             povf;
      logic             take;

      if (s == 0) begin : g_first
        // The quotient overflows 32 bits exactly when the upper dividend part reaches den.
        assign prem = REM_W'(in_dividend[l][DIV_W-1:QW]);
        assign plo  = in_dividend[l][QW-1:0];
        assign pq   = '0;
        assign povf = (REM_W'(in_dividend[l][DIV_W-1:QW]) >= dd);
      end else begin : g_next
        assign prem = rem[s-1][l];
        assign plo  = lo[s-1][l];
        assign pq   = quo[s-1][l];
        assign povf = ovf[s-1][l];
      end

      assign rsh  = {prem[REM_W-2:0], plo[J]};
      assign take = (rsh >= dd);

      always_comb begin
        qn    = pq;
        qn[J] = take;
      end

      always_ff @(posedge clk) begin
        if (en) begin
          rem[s][l] <= take ? (rsh - dd) : rsh;
          quo[s][l] <= qn;
          lo[s][l]  <= plo;
          ovf[s][l] <= povf;
        end
      end
    end
  end

  for (genvar l = 0; l < NL; l++) begin : g_out
    assign out_quo[l] = quo[QW-1][l];
    assign out_ovf[l] = ovf[QW-1][l];
  end

  assign out_valid = v[QW-1];
  assign out_root  = rt[QW-1];
  assign out_tag   = tag[QW-1];

endmodule

### src/rotation_matrix_to_quaternion_top.sv
// Top level of the rotation-matrix-to-quaternion converter (Shepperd's method).
// Uses rmq_pkg, rmq_sqrt_pipe and rmq_div_pipe.
`timescale 1ns / 1ps

// The block converts a 3x3 rotation matrix in signed fixed point with FRAC_BITS fraction
// bits into a quaternion (x, y, z, w) in the same format. It accepts one matrix
// transaction per clock cycle while in_ready is high and returns one quaternion
// transaction per matrix, in order. RW = (33 + FRAC_BITS + 1) / 2 is the square-root
// width, 32 bits at FRAC_BITS = 30.
// The pipeline is two front-end stages (radicand sums, then branch and radicand
// selection), one stage per root bit of the square-root pipe, one stage per quotient
// bit of the three-lane divider, and an output register. The whole pipeline shares one
// clock enable; a one-entry skid buffer behind the output register lets the pipeline
// deliver one more result after out_ready drops, and in_ready falls while that buffer
// is occupied. The trace branch is used when 1 + r00 + r11 + r22 is strictly greater
// than trace_threshold (reset value 1); otherwise the largest diagonal element picks a
// column branch. When the chosen radicand is zero or negative the four components are
// zero, degenerate is set and branch_used still reports the branch. Off-diagonal
// quotients are truncated toward zero and every component saturates to 32 bits.
// trace_threshold is written through cfg_wen/cfg_wdata and should only change while no
// transaction is in flight.

module rotation_matrix_to_quaternion_top #(
  parameter int FRAC_BITS = 30
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  rmq_pkg::matrix_t            in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output rmq_pkg::quat_t              out_data,
  input  logic                        cfg_wen,
  input  logic [rmq_pkg::THR_W-1:0]   cfg_wdata
);

  localparam int SUM_W  = rmq_pkg::SUM_W;
  localparam int NUM_W  = rmq_pkg::NUM_W;
  localparam int RAD_W  = rmq_pkg::RAD_W;
  localparam int THR_W  = rmq_pkg::THR_W;
  localparam int QW     = rmq_pkg::Q_W;
  localparam int NL     = rmq_pkg::N_LANES;
  localparam int BW     = rmq_pkg::BRANCH_W;
  localparam int RW     = (RAD_W + FRAC_BITS + 1) / 2;
  localparam int XW     = 2 * RW;
  localparam int DIV_W  = NUM_W + FRAC_BITS;
  localparam int TAG2_W = NL + BW + 1;
  localparam int TAG1_W = NL * DIV_W + TAG2_W;

  localparam logic signed [SUM_W-1:0] ONE = SUM_W'(1) <<< FRAC_BITS;

  // Configuration register.
  logic [THR_W-1:0] trace_threshold;

  always_ff @(posedge clk) begin
    if (rst) begin
      trace_threshold <= THR_W'(1);
    end else if (cfg_wen) begin
      trace_threshold <= cfg_wdata;
    end
  end

  // The whole pipeline advances together unless the skid buffer holds a result.
  logic sk_valid;
  logic en;

  assign en       = !sk_valid;
  assign in_ready = en;

  // Stage 1: all four radicands, diagonal comparisons and the six off-diagonal terms.
  logic signed [SUM_W-1:0] e00, e11, e22;
  logic signed [SUM_W-1:0] t_c, c0_c, c1_c, c2_c;

  assign e00  = SUM_W'(in_data.r00);
  assign e11  = SUM_W'(in_data.r11);
  assign e22  = SUM_W'(in_data.r22);
  assign t_c  = ONE + e00 + e11 + e22;
  assign c0_c = ONE + e00 - e11 - e22;
  assign c1_c = ONE + e11 - e00 - e22;
  assign c2_c = ONE + e22 - e00 - e11;

  logic                    s1_valid;
  logic signed [SUM_W-1:0] s1_t, s1_c0, s1_c1, s1_c2;
  logic                    s1_gt01, s1_gt02, s1_gt12;
  logic signed [NUM_W-1:0] s1_d21_12, s1_d02_20, s1_d10_01;
  logic signed [NUM_W-1:0] s1_s10_01, s1_s02_20, s1_s21_12;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_t      <= t_c;
      s1_c0     <= c0_c;
      s1_c1     <= c1_c;
      s1_c2     <= c2_c;
      s1_gt01   <= ($signed(in_data.r00) > $signed(in_data.r11));
      s1_gt02   <= ($signed(in_data.r00) > $signed(in_data.r22));
      s1_gt12   <= ($signed(in_data.r11) > $signed(in_data.r22));
      s1_d21_12 <= NUM_W'(in_data.r21) - NUM_W'(in_data.r12);
      s1_d02_20 <= NUM_W'(in_data.r02) - NUM_W'(in_data.r20);
      s1_d10_01 <= NUM_W'(in_data.r10) - NUM_W'(in_data.r01);
      s1_s10_01 <= NUM_W'(in_data.r10) + NUM_W'(in_data.r01);
      s1_s02_20 <= NUM_W'(in_data.r02) + NUM_W'(in_data.r20);
      s1_s21_12 <= NUM_W'(in_data.r21) + NUM_W'(in_data.r12);
    end
  end

  // Stage 2: pick the branch, its radicand and the three off-diagonal numerators.
  // Lanes hold the non-diagonal components in x, y, z, w order.
  logic                    take_trace;
  logic [BW-1:0]           br_c;
  logic signed [SUM_W-1:0] rad_c;
  logic signed [NUM_W-1:0] num_c [NL];
  logic                    degen_c;
  logic [RAD_W-1:0]        rad_u;
  logic [XW-1:0]           x_c;
  logic [NL-1:0]           sgn_c;
  logic [NL-1:0][DIV_W-1:0] d_c;

  assign take_trace = (s1_t > $signed({{(SUM_W-THR_W){1'b0}}, trace_threshold}));

  always_comb begin
    if (take_trace) begin
      br_c = rmq_pkg::BR_TRACE;
    end else if (s1_gt01 && s1_gt02) begin
      br_c = rmq_pkg::BR_COL0;
    end else if (s1_gt12) begin
      br_c = rmq_pkg::BR_COL1;
    end else begin
      br_c = rmq_pkg::BR_COL2;
    end
  end

  always_comb begin
    case (br_c)
      rmq_pkg::BR_TRACE: begin
        rad_c    = s1_t;
        num_c[0] = s1_d21_12;
        num_c[1] = s1_d02_20;
        num_c[2] = s1_d10_01;
      end
      rmq_pkg::BR_COL0: begin
        rad_c    = s1_c0;
        num_c[0] = s1_s10_01;
        num_c[1] = s1_s02_20;
        num_c[2] = s1_d21_12;
      end
      rmq_pkg::BR_COL1: begin
        rad_c    = s1_c1;
        num_c[0] = s1_s10_01;
        num_c[1] = s1_s21_12;
        num_c[2] = s1_d02_20;
      end
      default: begin
        rad_c    = s1_c2;
        num_c[0] = s1_s02_20;
        num_c[1] = s1_s21_12;
        num_c[2] = s1_d10_01;
      end
    endcase
  end

  assign degen_c = rad_c[SUM_W-1] || (rad_c == '0);
  assign rad_u   = rad_c[RAD_W-1:0];
  assign x_c     = XW'(rad_u) << FRAC_BITS;

  for (genvar l = 0; l < NL; l++) begin : g_num
    logic [NUM_W-1:0] mag;
    assign sgn_c[l] = num_c[l][NUM_W-1];
    assign mag      = sgn_c[l] ? NUM_W'(-num_c[l]) : NUM_W'(num_c[l]);
    assign d_c[l]   = DIV_W'(mag) << FRAC_BITS;
  end

  logic                      s2_valid;
  logic [XW-1:0]             s2_x;
  logic [NL-1:0][DIV_W-1:0]  s2_d;
  logic [NL-1:0]             s2_sgn;
  logic [BW-1:0]             s2_br;
  logic                      s2_degen;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_x     <= x_c;
      s2_d     <= d_c;
      s2_sgn   <= sgn_c;
      s2_br    <= br_c;
      s2_degen <= degen_c;
    end
  end

  // Square root of radicand * 2^FRAC_BITS; dividends and sideband ride along as a tag.
  logic              sq_valid;
  logic [RW-1:0]     sq_root;
  logic [TAG1_W-1:0] sq_tag;

  rmq_sqrt_pipe #(
    .RW    (RW),
    .TAG_W (TAG1_W)
  ) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s2_valid),
    .in_x      (s2_x),
    .in_tag    ({s2_d, s2_sgn, s2_br, s2_degen}),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_tag   (sq_tag)
  );

  // Off-diagonal components: (numerator * 2^FRAC_BITS) / (2 * root).
  logic                     dv_valid;
  logic [RW-1:0]            dv_root;
  logic [NL-1:0][QW-1:0]    dv_quo;
  logic [NL-1:0]            dv_ovf;
  logic [TAG2_W-1:0]        dv_tag;

  rmq_div_pipe #(
    .RW    (RW),
    .DIV_W (DIV_W),
    .TAG_W (TAG2_W)
  ) u_div (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .in_valid    (sq_valid),
    .in_root     (sq_root),
    .in_dividend (sq_tag[TAG1_W-1:TAG2_W]),
    .in_tag      (sq_tag[TAG2_W-1:0]),
    .out_valid   (dv_valid),
    .out_root    (dv_root),
    .out_quo     (dv_quo),
    .out_ovf     (dv_ovf),
    .out_tag     (dv_tag)
  );

  // Output assembly: sign, saturation and placement of the diagonal term.
  logic [NL-1:0] fin_sgn;
  logic [BW-1:0] fin_br;
  logic          fin_degen;
  logic [QW-1:0] comp [NL];
  logic [QW-1:0] diag;
  rmq_pkg::quat_t res_c;

  assign {fin_sgn, fin_br, fin_degen} = dv_tag;
  assign diag = QW'(dv_root >> 1);

  for (genvar l = 0; l < NL; l++) begin : g_sat
    always_comb begin
      if (dv_ovf[l]) begin
        comp[l] = fin_sgn[l] ? rmq_pkg::COMP_MIN : rmq_pkg::COMP_MAX;
      end else if (fin_sgn[l]) begin
        comp[l] = (dv_quo[l] > rmq_pkg::COMP_MIN) ? rmq_pkg::COMP_MIN : -dv_quo[l];
      end else begin
        comp[l] = dv_quo[l][QW-1] ? rmq_pkg::COMP_MAX : dv_quo[l];
      end
    end
  end

  always_comb begin
    res_c.branch_used = fin_br;
    res_c.degenerate  = fin_degen;
    case (fin_br)
      rmq_pkg::BR_TRACE: begin
        res_c.quat_x = comp[0];
        res_c.quat_y = comp[1];
        res_c.quat_z = comp[2];
        res_c.quat_w = diag;
      end
      rmq_pkg::BR_COL0: begin
        res_c.quat_x = diag;
        res_c.quat_y = comp[0];
        res_c.quat_z = comp[1];
        res_c.quat_w = comp[2];
      end
      rmq_pkg::BR_COL1: begin
        res_c.quat_x = comp[0];
        res_c.quat_y = diag;
        res_c.quat_z = comp[1];
        res_c.quat_w = comp[2];
      end
      default: begin
        res_c.quat_x = comp[0];
        res_c.quat_y = comp[1];
        res_c.quat_z = diag;
        res_c.quat_w = comp[2];
      end
    endcase
    if (fin_degen) begin
      res_c.quat_x = '0;
      res_c.quat_y = '0;
      res_c.quat_z = '0;
      res_c.quat_w = '0;
    end
  end

  // Output register and skid buffer. While the pipeline is enabled, the transaction
  // leaving the divider goes to the output register if that is free or being taken,
  // and to the skid buffer otherwise; a full skid buffer freezes the pipeline.
  rmq_pkg::quat_t sk_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sk_valid  <= 1'b0;
    end else if (sk_valid) begin
      if (out_ready) begin
        out_valid <= 1'b1;
        sk_valid  <= 1'b0;
      end
    end else if (!out_valid || out_ready) begin
      out_valid <= dv_valid;
    end else if (dv_valid) begin
      sk_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (sk_valid) begin
      if (out_ready) begin
        out_data <= sk_data;
      end
    end else if (!out_valid || out_ready) begin
      out_data <= res_c;
    end else begin
      sk_data <= res_c;
    end
  end

`ifndef SYNTHESIS
  // A result only waits in the skid buffer behind a result on the output.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    sk_valid |-> out_valid)
    else $error("skid buffer holds a transaction while the output is empty");

  // A stalled output never drops its transaction.
  a_out_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("output transaction lost while stalled");

  // A full skid buffer stays full until the output is taken.
  a_skid_holds: assert property (@(posedge clk) disable iff (rst)
    (sk_valid && !out_ready) |=> sk_valid)
    else $error("skid buffer emptied without an output handshake");

  // Degenerate results carry zero components.
  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.degenerate) |->
      (out_data.quat_x == '0) && (out_data.quat_y == '0) &&
      (out_data.quat_z == '0) && (out_data.quat_w == '0))
    else $error("degenerate result with nonzero components");

  // The diagonal component is half a square root and never negative; checked as w on the trace branch.
  a_diag_nonneg: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.branch_used == rmq_pkg::BR_TRACE) |-> !out_data.quat_w[QW-1])
    else $error("negative w component on the trace branch");
`endif

endmodule

### tb/rotation_matrix_to_quaternion_top_tb.sv
// Self-checking testbench for rotation_matrix_to_quaternion_top.
// Depends on rmq_pkg and the block's RTL; drives matrices and checks quaternions.
`timescale 1ns / 1ps

module rotation_matrix_to_quaternion_top_tb;

  localparam int FRAC = 30;
  localparam int LATENCY = 80;          // pipeline depth plus margin
  localparam int STALL_LIMIT = 5000;    // cycles without any transaction
  localparam int RANDOM_ITEMS = 1500;

  // Idle profiles: percentages of idle sender cycles and stalled receiver cycles.
  typedef enum int {PH_NONE, PH_SEND_IDLE, PH_RECV_STALL, PH_BOTH} idle_phase_t;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  rmq_pkg::matrix_t in_data;
  logic out_valid;
  logic out_ready;
  rmq_pkg::quat_t out_data;
  logic cfg_wen;
  logic [rmq_pkg::THR_W-1:0] cfg_wdata;

  // Current threshold as the predictor sees it.
  logic [rmq_pkg::THR_W-1:0] thr_shadow;
  rmq_pkg::quat_t quat_expected_q[$];
  int errors;
  int idle_cycles;
  int send_idle_pct;
  int recv_stall_pct;

  rotation_matrix_to_quaternion_top #(.FRAC_BITS(FRAC)) uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_wen(cfg_wen),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Integer square root, bit by bit, of a value below 2^63.
  function automatic logic [63:0] int_sqrt(input logic [63:0] val);
    logic [63:0] x;
    logic [63:0] res;
    logic [63:0] b;
    x = val;
    res = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x = x - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
    if (v > 64'sh7FFF_FFFF) return rmq_pkg::COMP_MAX;
    if (v < -64'sh8000_0000) return rmq_pkg::COMP_MIN;
    return v[31:0];
  endfunction

  // Off-diagonal component: (num << FRAC) / (2 * root), truncated toward zero.
  function automatic logic signed [31:0] off_diag(input logic signed [63:0] num,
                                                  input logic [63:0] root);
    logic [63:0] mag;
    logic [63:0] q;
    mag = (num < 0) ? -num : num;
    q = (mag << FRAC) / (root * 2);
    return clamp32((num < 0) ? -$signed(q) : $signed(q));
  endfunction

  function automatic rmq_pkg::quat_t convert_matrix(input rmq_pkg::matrix_t m,
                                                    input logic [rmq_pkg::THR_W-1:0] thr);
    rmq_pkg::quat_t q;
    logic signed [63:0] a00, a01, a02, a10, a11, a12, a20, a21, a22;
    logic signed [63:0] one;
    logic signed [63:0] tr;
    logic signed [63:0] rad;
    logic [63:0] root;
    logic signed [31:0] diag;
    a00 = m.r00; a01 = m.r01; a02 = m.r02;
    a10 = m.r10; a11 = m.r11; a12 = m.r12;
    a20 = m.r20; a21 = m.r21; a22 = m.r22;
    one = 64'sd1 <<< FRAC;
    tr = one + a00 + a11 + a22;
    q = '0;
    if (tr > $signed({33'd0, thr})) begin
      q.branch_used = rmq_pkg::BR_TRACE;
      rad = tr;
    end else if (a00 > a11 && a00 > a22) begin
      q.branch_used = rmq_pkg::BR_COL0;
      rad = one + a00 - a11 - a22;
    end else if (a11 > a22) begin
      q.branch_used = rmq_pkg::BR_COL1;
      rad = one + a11 - a00 - a22;
    end else begin
      q.branch_used = rmq_pkg::BR_COL2;
      rad = one + a22 - a00 - a11;
    end
    if (rad <= 0) begin
      q.degenerate = 1'b1;
      return q;
    end
    root = int_sqrt(rad << FRAC);
    diag = clamp32($signed(root >> 1));
    case (q.branch_used)
      rmq_pkg::BR_TRACE: begin
        q.quat_x = off_diag(a21 - a12, root);
        q.quat_y = off_diag(a02 - a20, root);
        q.quat_z = off_diag(a10 - a01, root);
        q.quat_w = diag;
      end
      rmq_pkg::BR_COL0: begin
        q.quat_x = diag;
        q.quat_y = off_diag(a10 + a01, root);
        q.quat_z = off_diag(a02 + a20, root);
        q.quat_w = off_diag(a21 - a12, root);
      end
      rmq_pkg::BR_COL1: begin
        q.quat_x = off_diag(a10 + a01, root);
        q.quat_y = diag;
        q.quat_z = off_diag(a21 + a12, root);
        q.quat_w = off_diag(a02 - a20, root);
      end
      default: begin
        q.quat_x = off_diag(a02 + a20, root);
        q.quat_y = off_diag(a21 + a12, root);
        q.quat_z = diag;
        q.quat_w = off_diag(a10 - a01, root);
      end
    endcase
    return q;
  endfunction

  // Sends one matrix transaction, with a random idle gap first, and records the
  // expected quaternion when the handshake completes. Valid stays high after the
  // handshake so that back-to-back transactions need no extra edge.
  task automatic send_matrix(input rmq_pkg::matrix_t m);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= m;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    quat_expected_q.push_back(convert_matrix(m, thr_shadow));
  endtask

  // Waits until every expected quaternion has come back, then lets the pipe drain.
  task automatic drain_pipe();
    in_valid <= 1'b0;
    while (quat_expected_q.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [rmq_pkg::THR_W-1:0] value);
    cfg_wen <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wen <= 1'b0;
    thr_shadow = value;
  endtask

  function automatic logic signed [31:0] rand_elem();
    case ($urandom_range(5))
      0: return 32'sh4000_0000;
      1: return -32'sh4000_0000;
      2: return $signed(rmq_pkg::COMP_MAX);
      3: return $signed(rmq_pkg::COMP_MIN);
      default: return $signed($urandom);
    endcase
  endfunction

  // Near-rotation: identity-like diagonal with perturbations, so that every branch
  // and sane quotients occur; full-range values make up the rest.
  function automatic rmq_pkg::matrix_t rand_matrix();
    rmq_pkg::matrix_t m;
    int hot;
    logic signed [31:0] jit [9];
    for (int i = 0; i < 9; i++) jit[i] = $signed($urandom_range(32'h1FFF_FFFF)) - 32'sh1000_0000;
    if ($urandom_range(3) == 0) begin
      m = {rand_elem(), rand_elem(), rand_elem(), rand_elem(), rand_elem(),
           rand_elem(), rand_elem(), rand_elem(), rand_elem()};
    end else begin
      hot = $urandom_range(3);
      m.r00 = (hot == 1 || hot == 0) ? 32'sh3000_0000 + jit[0] : -32'sh2000_0000 + jit[0];
      m.r11 = (hot == 2 || hot == 0) ? 32'sh3000_0000 + jit[4] : -32'sh2000_0000 + jit[4];
      m.r22 = (hot == 3 || hot == 0) ? 32'sh3000_0000 + jit[8] : -32'sh2000_0000 + jit[8];
      m.r01 = jit[1]; m.r02 = jit[2]; m.r10 = jit[3];
      m.r12 = jit[5]; m.r20 = jit[6]; m.r21 = jit[7];
    end
    return m;
  endfunction

  // Directed rows. Where the expected value is obvious it is typed in as well.
  typedef struct {
    rmq_pkg::matrix_t m;
    logic             known;
    rmq_pkg::quat_t   q;
  } stim_row_t;

  localparam logic signed [31:0] ONE = 32'sh4000_0000;
  localparam logic signed [31:0] MAXV = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] MINV = -32'sh8000_0000;

  stim_row_t stim_table [14] = '{
    // Identity: trace branch, w = 1.0.
    '{'{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE}, 1'b1,
      '{32'sd0, 32'sd0, 32'sd0, ONE, rmq_pkg::BR_TRACE, 1'b0}},
    // All zero: trace T = 1.0 passes the reset threshold of one LSB.
    '{'{0, 0, 0, 0, 0, 0, 0, 0, 0}, 1'b0, '0},
    // Half-turns about each axis pick the column branches.
    '{'{ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE}, 1'b1,
      '{ONE, 32'sd0, 32'sd0, 32'sd0, rmq_pkg::BR_COL0, 1'b0}},
    '{'{-ONE, 0, 0, 0, ONE, 0, 0, 0, -ONE}, 1'b1,
      '{32'sd0, ONE, 32'sd0, 32'sd0, rmq_pkg::BR_COL1, 1'b0}},
    '{'{-ONE, 0, 0, 0, -ONE, 0, 0, 0, ONE}, 1'b1,
      '{32'sd0, 32'sd0, ONE, 32'sd0, rmq_pkg::BR_COL2, 1'b0}},
    // All most negative: a tied diagonal falls through to column 2.
    '{'{MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV}, 1'b0, '0},
    // All most positive: trace branch with large quotient inputs of zero.
    '{'{MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV}, 1'b0, '0},
    // Tiny trace radicand with large off-diagonals saturates the quotients.
    '{'{-ONE + 1, MINV, MAXV, MAXV, 0, MINV, MINV, MAXV, 1}, 1'b0, '0},
    '{'{-ONE + 1, MAXV, MINV, MINV, 0, MAXV, MAXV, MINV, 1}, 1'b0, '0},
    // Ties on the diagonal fall through to column 1 or column 2.
    '{'{-ONE, 5, 7, 9, -ONE, 11, 13, 15, -ONE + 2}, 1'b0, '0},
    '{'{-ONE, 1, 2, 3, -ONE + 4, 5, 6, 7, -ONE}, 1'b0, '0},
    // Trace exactly at the threshold (one LSB) is not enough for the trace branch.
    '{'{-ONE + 1, 3, 4, 5, 0, 6, 7, 8, 0}, 1'b0, '0},
    // Opposite diagonal halves leave a trace of exactly 1.0.
    '{'{0, 9, 9, 9, -32'sh2000_0000, 9, 9, 9, 32'sh6000_0000 - ONE}, 1'b0, '0},
    // Mixed signs of the off-diagonals.
    '{'{32'sh2000_0000, -32'sh1234_5678, 32'sh0765_4321, 32'sh1234_5678,
        32'sh2000_0000, -32'sh0FED_CBA9, -32'sh0765_4321, 32'sh0FED_CBA9,
        32'sh2000_0000}, 1'b0, '0}
  };

  // Every transaction on the output is compared with the oldest expectation.
  always @(posedge clk) begin
    rmq_pkg::quat_t exp_q;
    if (!rst && out_valid && out_ready) begin
      if (quat_expected_q.size() == 0) begin
        $display("%0t: unexpected quaternion %h", $time, out_data);
        errors++;
      end else begin
        exp_q = quat_expected_q.pop_front();
        if (out_data.quat_x !== exp_q.quat_x) begin
          $display("%0t: quat_x expected %h actual %h", $time, exp_q.quat_x, out_data.quat_x);
          errors++;
        end
        if (out_data.quat_y !== exp_q.quat_y) begin
          $display("%0t: quat_y expected %h actual %h", $time, exp_q.quat_y, out_data.quat_y);
          errors++;
        end
        if (out_data.quat_z !== exp_q.quat_z) begin
          $display("%0t: quat_z expected %h actual %h", $time, exp_q.quat_z, out_data.quat_z);
          errors++;
        end
        if (out_data.quat_w !== exp_q.quat_w) begin
          $display("%0t: quat_w expected %h actual %h", $time, exp_q.quat_w, out_data.quat_w);
          errors++;
        end
        if (out_data.branch_used !== exp_q.branch_used) begin
          $display("%0t: branch_used expected %0d actual %0d", $time,
                   exp_q.branch_used, out_data.branch_used);
          errors++;
        end
        if (out_data.degenerate !== exp_q.degenerate) begin
          $display("%0t: degenerate expected %0b actual %0b", $time,
                   exp_q.degenerate, out_data.degenerate);
          errors++;
        end
      end
    end
  end

  // The receiver stalls at random according to the current phase.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog: a long stretch without any transaction ends the run.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || rst) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("rotation_matrix_to_quaternion_top_tb failed");
        $finish;
      end
    end
  end

  function automatic void set_phase(input idle_phase_t ph);
    case (ph)
      PH_NONE:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      PH_SEND_IDLE:  begin send_idle_pct = 68; recv_stall_pct = 0;  end
      PH_RECV_STALL: begin send_idle_pct = 0;  recv_stall_pct = 68; end
      default:       begin send_idle_pct = 22; recv_stall_pct = 22; end
    endcase
  endfunction

  initial begin
    logic [rmq_pkg::THR_W-1:0] thresholds [6];
    rmq_pkg::quat_t typed_q;
    errors = 0;
    idle_cycles = 0;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_wen = 1'b0;
    cfg_wdata = '0;
    out_ready = 1'b0;
    thr_shadow = 1;
    set_phase(PH_NONE);
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part under the reset threshold. Typed expectations are checked
    // against the predictor so that a wrong row cannot hide.
    foreach (stim_table[i]) begin
      if (stim_table[i].known) begin
        typed_q = convert_matrix(stim_table[i].m, thr_shadow);
        if (typed_q !== stim_table[i].q) begin
          $display("%0t: directed row %0d expected %h actual %h", $time, i,
                   stim_table[i].q, typed_q);
          errors++;
        end
      end
      send_matrix(stim_table[i].m);
    end
    // Sender holds off until every result has arrived.
    drain_pipe();

    // Random part across thresholds and idle phases.
    thresholds = '{31'd0, 31'h7FFF_FFFF, 31'h4000_0000, 31'h1000_0000, 31'h6000_0000, 31'd1};
    for (int p = 0; p < 6; p++) begin
      write_threshold(thresholds[p]);
      for (int i = 0; i < RANDOM_ITEMS / 6; i++) begin
        // Each setting sweeps the four idle profiles, one of them with no idling.
        if (i % 63 == 0) set_phase(idle_phase_t'((i / 63) % 4));
        send_matrix(rand_matrix());
      end
      set_phase(PH_NONE);
      drain_pipe();
    end

    if (errors == 0) begin
      $display("rotation_matrix_to_quaternion_top_tb passed");
    end else begin
      $display("rotation_matrix_to_quaternion_top_tb failed");
    end
    $finish;
  end

endmodule
